[src/bb_pkg.sv]
// ----------------------------------------------------------------------------
// Bouncing ball step package
// Widths, register indexes, constants, item types and saturation shared by
// the ball step sequencer and its serial multiplier.
// ----------------------------------------------------------------------------
package bb_pkg;

    localparam int VALUE_BITS = 24;
    localparam int TIME_BITS  = 16;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int RAD_W     = 18;
    localparam int AREA_W    = 23;
    localparam int GRAV_W    = 20;
    localparam int Q_BITS    = 16;

    localparam int MUL_B_W   = (TIME_BITS > Q_BITS) ? TIME_BITS : Q_BITS;
    localparam int MUL_A_W   = (VALUE_BITS + 1 > GRAV_W + 1) ? VALUE_BITS + 1 : GRAV_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int WIDE_W    = PROD_W + 1;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 3'd5;

    localparam logic [RAD_W-1:0]  RADIUS_RST  = RAD_W'(2560);
    localparam logic [AREA_W-1:0] WIDTH_RST   = AREA_W'(204800);
    localparam logic [AREA_W-1:0] HEIGHT_RST  = AREA_W'(115200);
    localparam logic [GRAV_W-1:0] GRAVITY_RST = GRAV_W'(250880);

    localparam logic [MUL_B_W-1:0] DAMP_Q16     = MUL_B_W'(52429);
    localparam logic [MUL_B_W-1:0] FRICTION_Q16 = MUL_B_W'(64225);

    typedef logic signed [VALUE_BITS-1:0] t_val;
    typedef logic signed [WIDE_W-1:0]     t_wide;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [MUL_A_W-1:0]    t_mula;
    typedef logic signed [CFG_W-1:0]      t_start;

    localparam t_val VMAX_V      = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam t_val VMIN_V      = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam t_val START_VX    = VALUE_BITS'(25600);
    localparam t_val STOP_LIMIT  = VALUE_BITS'(-2560);

    typedef struct packed {
        logic                 restart;
        logic [TIME_BITS-1:0] delta_time;
    } t_in_item;

    typedef struct packed {
        t_val pos_x;
        t_val pos_y;
        t_val vel_x;
        t_val vel_y;
    } t_out_item;

    typedef struct packed {
        logic               start;
        t_mula              a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_prod prod;
    } t_mul_rsp;

    function automatic t_val sat_val(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = t_wide'(VMAX_V);
        lo = t_wide'(VMIN_V);
        if (v > hi) begin
            return VMAX_V;
        end else if (v < lo) begin
            return VMIN_V;
        end
        return v[VALUE_BITS-1:0];
    endfunction

endpackage

[src/bb_smul.sv]
// ----------------------------------------------------------------------------
// Bouncing ball serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, signed multiplicand
// by unsigned multiplier, full-width product with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module bb_smul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bb_pkg::t_mul_req i_req,
    output bb_pkg::t_mul_rsp o_rsp
);
    import bb_pkg::*;

    t_prod                r_a;
    logic [MUL_B_W-1:0]   r_b;
    t_prod                r_acc;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= t_prod'(i_req.a);
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= MUL_CNT_W'(MUL_B_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

[src/bouncing_ball_step.sv]
// ----------------------------------------------------------------------------
// Bouncing ball step
// Holds one ball's position and velocity and advances them one Euler step
// per item, with damped bounces on the four walls.
// ----------------------------------------------------------------------------
// Order: a restart item goes straight to the output step; a step item runs
//   gravity, both moves and the wall checks, with 3 to 8 multiplies.
// Throughput: one item at a time, set by the bit-serial multiplier that all
//   products share; the next item is taken while the result waits.
// Reset: synchronous, active low; ball at (0,0), velocity (25600,0),
//   registers to their defaults.
module bouncing_ball_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bb_pkg::t_in_item            i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bb_pkg::t_out_item           o_out_data,
    input  logic                        i_cfg_we,
    input  logic [bb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bb_pkg::CFG_W-1:0]    i_cfg_data
);
    import bb_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_GRAV      = 4'd1;
    localparam logic [3:0] S_MOVX      = 4'd2;
    localparam logic [3:0] S_MOVY      = 4'd3;
    localparam logic [3:0] S_LEFT      = 4'd4;
    localparam logic [3:0] S_LEFT_M    = 4'd5;
    localparam logic [3:0] S_RIGHT     = 4'd6;
    localparam logic [3:0] S_RIGHT_M   = 4'd7;
    localparam logic [3:0] S_GROUND    = 4'd8;
    localparam logic [3:0] S_GROUND_MY = 4'd9;
    localparam logic [3:0] S_GROUND_MX = 4'd10;
    localparam logic [3:0] S_CEIL      = 4'd11;
    localparam logic [3:0] S_CEIL_M    = 4'd12;
    localparam logic [3:0] S_OUT       = 4'd13;

    logic [3:0]           r_state;
    logic                 r_mwait;
    logic                 r_out_valid;
    t_out_item            r_out;
    t_val                 r_px;
    t_val                 r_py;
    t_val                 r_vx;
    t_val                 r_vy;
    logic [TIME_BITS-1:0] r_dt;

    t_start               r_start_x;
    t_start               r_start_y;
    logic [RAD_W-1:0]     r_radius;
    logic [AREA_W-1:0]    r_width;
    logic [AREA_W-1:0]    r_height;
    logic [GRAV_W-1:0]    r_grav;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    logic     mul_state;

    t_wide px_w, py_w, rad_w, width_w, height_w, prod_t_w, prod_q_w;
    logic  left_hit, right_hit, ground_hit, ceil_hit;

    bb_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign px_w     = t_wide'(r_px);
    assign py_w     = t_wide'(r_py);
    assign rad_w    = t_wide'($signed({1'b0, r_radius}));
    assign width_w  = t_wide'($signed({1'b0, r_width}));
    assign height_w = t_wide'($signed({1'b0, r_height}));
    assign prod_t_w = t_wide'(mul_rsp.prod >>> TIME_BITS);
    assign prod_q_w = t_wide'(mul_rsp.prod >>> Q_BITS);

    assign left_hit   = (px_w - rad_w) < t_wide'(0);
    assign right_hit  = (px_w + rad_w) > width_w;
    assign ground_hit = (py_w + rad_w) > height_w;
    assign ceil_hit   = (py_w - rad_w) < t_wide'(0);

    always_comb begin
        mul_state = 1'b1;
        mul_req.a = t_mula'(r_vx);
        mul_req.b = MUL_B_W'(r_dt);
        case (r_state)
            S_GRAV: begin
                mul_req.a = t_mula'($signed({1'b0, r_grav}));
            end
            S_MOVX: begin
                mul_req.a = t_mula'(r_vx);
            end
            S_MOVY: begin
                mul_req.a = t_mula'(r_vy);
            end
            S_LEFT_M, S_RIGHT_M: begin
                mul_req.a = -t_mula'(r_vx);
                mul_req.b = DAMP_Q16;
            end
            S_GROUND_MY, S_CEIL_M: begin
                mul_req.a = -t_mula'(r_vy);
                mul_req.b = DAMP_Q16;
            end
            S_GROUND_MX: begin
                mul_req.a = t_mula'(r_vx);
                mul_req.b = FRICTION_Q16;
            end
            default: begin
                mul_state = 1'b0;
            end
        endcase
        mul_req.start = mul_state && !r_mwait;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mwait     <= 1'b0;
            r_out_valid <= 1'b0;
            r_px        <= '0;
            r_py        <= '0;
            r_vx        <= START_VX;
            r_vy        <= '0;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_radius    <= RADIUS_RST;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_grav      <= GRAVITY_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START_X: r_start_x <= i_cfg_data;
                    REG_START_Y: r_start_y <= i_cfg_data;
                    REG_RADIUS:  r_radius  <= i_cfg_data[RAD_W-1:0];
                    REG_WIDTH:   r_width   <= i_cfg_data[AREA_W-1:0];
                    REG_HEIGHT:  r_height  <= i_cfg_data[AREA_W-1:0];
                    REG_GRAVITY: r_grav    <= i_cfg_data[GRAV_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.restart) begin
                            r_px    <= sat_val(t_wide'(r_start_x));
                            r_py    <= sat_val(t_wide'(r_start_y));
                            r_vx    <= START_VX;
                            r_vy    <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_dt    <= i_in_data.delta_time;
                            r_state <= S_GRAV;
                        end
                    end
                end
                S_GRAV: begin
                    if (mul_rsp.done) begin
                        r_vy    <= sat_val(t_wide'(r_vy) + prod_t_w);
                        r_state <= S_MOVX;
                    end
                end
                S_MOVX: begin
                    if (mul_rsp.done) begin
                        r_px    <= sat_val(px_w + prod_t_w);
                        r_state <= S_MOVY;
                    end
                end
                S_MOVY: begin
                    if (mul_rsp.done) begin
                        r_py    <= sat_val(py_w + prod_t_w);
                        r_state <= S_LEFT;
                    end
                end
                S_LEFT: begin
                    if (left_hit) begin
                        r_px    <= sat_val(rad_w);
                        r_state <= S_LEFT_M;
                    end else begin
                        r_state <= S_RIGHT;
                    end
                end
                S_LEFT_M: begin
                    if (mul_rsp.done) begin
                        r_vx    <= sat_val(prod_q_w);
                        r_state <= S_RIGHT;
                    end
                end
                S_RIGHT: begin
                    if (right_hit) begin
                        r_px    <= sat_val(width_w - rad_w);
                        r_state <= S_RIGHT_M;
                    end else begin
                        r_state <= S_GROUND;
                    end
                end
                S_RIGHT_M: begin
                    if (mul_rsp.done) begin
                        r_vx    <= sat_val(prod_q_w);
                        r_state <= S_GROUND;
                    end
                end
                S_GROUND: begin
                    if (ground_hit) begin
                        r_py    <= sat_val(height_w - rad_w);
                        r_state <= S_GROUND_MY;
                    end else begin
                        r_state <= S_CEIL;
                    end
                end
                S_GROUND_MY: begin
                    if (mul_rsp.done) begin
                        r_vy    <= sat_val(prod_q_w);
                        r_state <= S_GROUND_MX;
                    end
                end
                S_GROUND_MX: begin
                    if (mul_rsp.done) begin
                        r_vx <= sat_val(prod_q_w);
                        // drop a slow upward bounce
                        if (r_vy > STOP_LIMIT && r_vy < t_val'(0)) begin
                            r_vy <= '0;
                        end
                        r_state <= S_CEIL;
                    end
                end
                S_CEIL: begin
                    if (ceil_hit) begin
                        r_py    <= sat_val(rad_w);
                        r_state <= S_CEIL_M;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_CEIL_M: begin
                    if (mul_rsp.done) begin
                        r_vy    <= sat_val(prod_q_w);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.pos_x <= r_px;
                        r_out.pos_y <= r_py;
                        r_out.vel_x <= r_vx;
                        r_out.vel_y <= r_vy;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (mul_req.start) begin
                r_mwait <= 1'b1;
            end else if (mul_rsp.done) begin
                r_mwait <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_done_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> r_mwait)
        else $error("multiplier done without an issued product");

    a_start_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_req.start |=> !mul_req.start)
        else $error("multiplier started twice in a row");

    a_step_begins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && !i_in_data.restart) |=> (r_state == S_GRAV))
        else $error("step item did not start with gravity");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output step");

endmodule

[dv/bouncing_ball_step_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bouncing ball step checker
// Follows register writes and accepted items, runs its own Euler step with
// damped wall bounces to predict the ball state after each item, and
// compares every returned state, field by field, in order.
// ----------------------------------------------------------------------------
module bouncing_ball_step_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  bb_pkg::t_in_item             i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  bb_pkg::t_out_item            i_out_data,
    input  logic                         i_cfg_we,
    input  logic [bb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bb_pkg::CFG_W-1:0]     i_cfg_data,
    output int                           o_pending,
    output int                           o_fails,
    output int                           o_checked
);
    import bb_pkg::*;

    localparam int     FRAC_SHIFT = 16;
    localparam longint DAMP       = 52429;
    localparam longint FRICTION   = 64225;
    localparam longint STOP_VEL   = -2560;
    localparam longint LAUNCH_VX  = 25600;
    localparam longint VAL_HI     = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
    localparam longint VAL_LO     = -VAL_HI - 1;

    t_start            start_x_q;
    t_start            start_y_q;
    logic [RAD_W-1:0]  radius_q;
    logic [AREA_W-1:0] width_q;
    logic [AREA_W-1:0] height_q;
    logic [GRAV_W-1:0] gravity_q;

    t_val ball_px;
    t_val ball_py;
    t_val ball_vx;
    t_val ball_vy;

    t_out_item ball_states[$];
    t_out_item want;
    int        fail_total  = 0;
    int        check_total = 0;

    function automatic longint clip(input longint v);
        if (v > VAL_HI) begin
            return VAL_HI;
        end
        if (v < VAL_LO) begin
            return VAL_LO;
        end
        return v;
    endfunction

    function automatic longint rebound(input longint v);
        return clip((v * -DAMP) >>> FRAC_SHIFT);
    endfunction

    task automatic advance_ball(input t_in_item it, output t_out_item res);
        longint dt;
        longint r;
        longint px;
        longint py;
        longint vx;
        longint vy;
        dt = longint'(it.delta_time);
        r  = longint'(radius_q);
        px = longint'(ball_px);
        py = longint'(ball_py);
        vx = longint'(ball_vx);
        vy = longint'(ball_vy);
        if (it.restart) begin
            px = clip(longint'(start_x_q));
            py = clip(longint'(start_y_q));
            vx = clip(LAUNCH_VX);
            vy = 0;
        end else begin
            vy = clip(vy + ((longint'(gravity_q) * dt) >>> TIME_BITS));
            px = clip(px + ((vx * dt) >>> TIME_BITS));
            py = clip(py + ((vy * dt) >>> TIME_BITS));
            if (px - r < 0) begin
                px = clip(r);
                vx = rebound(vx);
            end
            if (px + r > longint'(width_q)) begin
                px = clip(longint'(width_q) - r);
                vx = rebound(vx);
            end
            if (py + r > longint'(height_q)) begin
                py = clip(longint'(height_q) - r);
                vy = rebound(vy);
                vx = clip((vx * FRICTION) >>> FRAC_SHIFT);
                if (vy > STOP_VEL && vy < 0) begin
                    vy = 0;
                end
            end
            if (py - r < 0) begin
                py = clip(r);
                vy = rebound(vy);
            end
        end
        ball_px = px[VALUE_BITS-1:0];
        ball_py = py[VALUE_BITS-1:0];
        ball_vx = vx[VALUE_BITS-1:0];
        ball_vy = vy[VALUE_BITS-1:0];
        res.pos_x = ball_px;
        res.pos_y = ball_py;
        res.vel_x = ball_vx;
        res.vel_y = ball_vy;
    endtask

    task automatic check_field(input string name, input t_val want_v, input t_val got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_x_q = '0;
            start_y_q = '0;
            radius_q  = RADIUS_RST;
            width_q   = WIDTH_RST;
            height_q  = HEIGHT_RST;
            gravity_q = GRAVITY_RST;
            ball_px   = '0;
            ball_py   = '0;
            ball_vx   = t_val'(LAUNCH_VX);
            ball_vy   = '0;
            ball_states.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START_X: start_x_q = t_start'(i_cfg_data);
                    REG_START_Y: start_y_q = t_start'(i_cfg_data);
                    REG_RADIUS:  radius_q  = i_cfg_data[RAD_W-1:0];
                    REG_WIDTH:   width_q   = i_cfg_data[AREA_W-1:0];
                    REG_HEIGHT:  height_q  = i_cfg_data[AREA_W-1:0];
                    REG_GRAVITY: gravity_q = i_cfg_data[GRAV_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (ball_states.size() == 0) begin
                    $error("unexpected result: pos_x %0d pos_y %0d vel_x %0d vel_y %0d",
                           i_out_data.pos_x, i_out_data.pos_y,
                           i_out_data.vel_x, i_out_data.vel_y);
                    fail_total++;
                end else begin
                    want = ball_states.pop_front();
                    check_field("pos_x", want.pos_x, i_out_data.pos_x);
                    check_field("pos_y", want.pos_y, i_out_data.pos_y);
                    check_field("vel_x", want.vel_x, i_out_data.vel_x);
                    check_field("vel_y", want.vel_y, i_out_data.vel_y);
                    check_total++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_ball(i_in_data, want);
                ball_states.push_back(want);
            end
        end
        o_pending <= ball_states.size();
        o_fails   <= fail_total;
        o_checked <= check_total;
    end

endmodule

[dv/bouncing_ball_step_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bouncing ball step testbench
// Drives items and register settings into the ball step block with random
// gaps and output stalls, including two long output hold-offs, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module bouncing_ball_step_tb;
    import bb_pkg::*;

    localparam int ITEMS_TOTAL  = 1700;
    localparam int PHASES       = 7;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 2000000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int pending;
    int fails;
    int checked;
    int cycles      = 0;
    int stall_left  = 0;
    int hold_asks   = 0;
    int hold_served = 0;
    int sent        = 0;
    int restarts    = 0;
    int settings    = 0;
    int calm_items  = 0;

    bouncing_ball_step dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    bouncing_ball_step_checker ball_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_fails     (fails),
        .o_checked   (checked)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 88) begin
            return $urandom_range(1, 4);
        end
        if (roll < 97) begin
            return $urandom_range(5, 20);
        end
        return $urandom_range(21, 60);
    endfunction

    always @(posedge clk) begin : receiver
        int g;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (hold_asks != hold_served) begin
            hold_served <= hold_served + 1;
            out_stall   <= 1'b1;
            stall_left  <= HOLD_CYCLES;
        end else if ($urandom_range(0, 199) == 0) begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(200, 1200);
        end else begin
            g = gap_len();
            out_stall  <= (g != 0);
            stall_left <= (g == 0) ? 0 : g - 1;
        end
    end

    task automatic send_item(input logic rs, input logic [TIME_BITS-1:0] dt);
        int       gap;
        t_in_item it;
        if (calm_items > 0) begin
            calm_items--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) == 0) begin
                calm_items = $urandom_range(20, 80);
            end
            gap = gap_len();
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.restart    = rs;
        it.delta_time = dt;
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        if (rs) begin
            restarts++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_setting(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
                                input logic [CFG_W-1:0] rad, input logic [CFG_W-1:0] wid,
                                input logic [CFG_W-1:0] hgt, input logic [CFG_W-1:0] grav,
                                input bit spare);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_WIDTH, wid);
        write_reg(REG_HEIGHT, hgt);
        write_reg(REG_GRAVITY, grav);
        if (spare) begin
            write_reg(REG_SPARE_LO, CFG_W'($urandom()));
            write_reg(REG_SPARE_HI, CFG_W'($urandom()));
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin : stimulus
        int                   r;
        int                   w;
        int                   h;
        int                   roll;
        logic [TIME_BITS-1:0] dt;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(1'b0, 0);
        send_item(1'b0, '1);
        send_item(1'b1, '1);
        send_item(1'b0, 1092);
        send_item(1'b0, 1092);
        send_item(1'b0, 0);

        drain_results();
        load_setting(100000, 112640, 2560, 204800, 115200, 10000, 1'b0);
        send_item(1'b1, 0);
        send_item(1'b0, 1092);
        send_item(1'b0, 1092);
        send_item(1'b0, 1092);

        drain_results();
        load_setting(204800, 50000, 2560, 204800, 115200, CFG_W'(GRAVITY_RST), 1'b0);
        send_item(1'b1, 5000);
        send_item(1'b0, 5000);
        send_item(1'b0, '1);

        drain_results();
        load_setting(500, 500, 262143, 1000, 0, 0, 1'b1);
        send_item(1'b1, 0);
        send_item(1'b0, 100);
        send_item(1'b0, '1);

        drain_results();
        load_setting(24'h800000, 24'h7FFFFF, 0, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFF, 1'b0);
        send_item(1'b1, '1);
        repeat (4) send_item(1'b0, '1);

        drain_results();
        load_setting(0, 0, 0, 0, 0, 0, 1'b1);
        send_item(1'b1, 0);
        send_item(1'b0, '1);
        send_item(1'b0, 0);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    load_setting(60000, 20000, CFG_W'(RADIUS_RST), CFG_W'(WIDTH_RST),
                                 CFG_W'(HEIGHT_RST), CFG_W'(GRAVITY_RST), 1'b0);
                end
                2: begin
                    load_setting(24'h7FFFFF, 24'h800000, 24'h3FFFF, 24'h7FFFFF,
                                 24'h7FFFFF, 24'hFFFFF, 1'b1);
                end
                3: begin
                    r = $urandom_range(1000, 262143);
                    load_setting(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'(r),
                                 CFG_W'($urandom_range(0, 2 * r)),
                                 CFG_W'($urandom_range(0, 2 * r)),
                                 CFG_W'($urandom_range(0, 1048575)), 1'b0);
                end
                4: begin
                    load_setting(24'h800000, 24'h800000, 0, 0, 0, 0, 1'b0);
                end
                6: begin
                    load_setting(CFG_W'($urandom()), CFG_W'($urandom()),
                                 CFG_W'($urandom()), CFG_W'($urandom()),
                                 CFG_W'($urandom()), CFG_W'($urandom()), 1'b1);
                end
                default: begin
                    r = $urandom_range(0, 16000);
                    w = $urandom_range(2 * r + 1000, 400000);
                    h = $urandom_range(2 * r + 1000, 400000);
                    load_setting(CFG_W'($urandom_range(0, w)), CFG_W'($urandom_range(0, h)),
                                 CFG_W'(r), CFG_W'(w), CFG_W'(h),
                                 CFG_W'($urandom_range(0, 1048575)), 1'b0);
                end
            endcase
            if (p == 0 || p == 3) begin
                hold_asks <= hold_asks + 1;
            end
            send_item(1'b1, TIME_BITS'($urandom()));
            repeat (ITEMS_TOTAL / PHASES - 1) begin
                roll = $urandom_range(0, 9);
                if (roll < 5) begin
                    dt = TIME_BITS'($urandom_range(0, 4096));
                end else if (roll < 8) begin
                    dt = TIME_BITS'($urandom());
                end else if (roll < 9) begin
                    dt = TIME_BITS'($urandom_range(0, 15));
                end else begin
                    dt = TIME_BITS'($urandom_range(60000, 65535));
                end
                send_item($urandom_range(0, 33) == 0, dt);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d items (%0d restarts) under %0d register settings",
                 sent, restarts, settings);
        $display("%0d results compared; output held off %0d times for %0d cycles",
                 checked, hold_served, HOLD_CYCLES);
        if (fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
